FILE: rtl/kbt_alu_pkg.sv
// ----------------------------------------------------------------------------
// kbt_alu_pkg
// Operation codes and internal step kinds of the known-bits transfer unit.
// ----------------------------------------------------------------------------
package kbt_alu_pkg;

   // operation codes carried on req_func
   typedef enum logic [4:0] {
      FN_AND  = 5'd0,
      FN_OR   = 5'd1,
      FN_XOR  = 5'd2,
      FN_NOT  = 5'd3,
      FN_ADD  = 5'd4,
      FN_SUB  = 5'd5,
      FN_NEG  = 5'd6,
      FN_MUL  = 5'd7,
      FN_SHL  = 5'd8,
      FN_SHR  = 5'd9,
      FN_SHRS = 5'd10,
      FN_MUX  = 5'd11,
      FN_JOIN = 5'd12,
      FN_MEET = 5'd13,
      FN_EQ   = 5'd14,
      FN_NE   = 5'd15,
      FN_LT   = 5'd16,
      FN_LE   = 5'd17,
      FN_GT   = 5'd18,
      FN_GE   = 5'd19
   } func_type;

   // what the iteration stages do with an item
   typedef enum logic [2:0] {
      KIND_PASS = 3'd0,
      KIND_MUL  = 3'd1,
      KIND_SHL  = 3'd2,
      KIND_SHR  = 3'd3,
      KIND_SHRS = 3'd4
   } kind_type;

endpackage

FILE: rtl/known_bits_transfer_alu_unit.sv
// ----------------------------------------------------------------------------
// known_bits_transfer_alu_unit
// Pipelined known-bits transfer unit: may-one / must-one masks in and out.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while the result side does not stall and
// returns each result from the last iteration stage. The depth is set by the
// multiply and variable-shift rules: one pipeline stage handles one bit of
// the multiplier, or one candidate shift amount, so there are WIDTH such
// stages behind an input register and a decode/simple-op stage. Every other
// operation is resolved in the decode stage and rides through. A stall on
// the result side freezes the whole pipeline; nothing is lost or repeated.
module known_bits_transfer_alu_unit
   import kbt_alu_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_func,
   input  logic [31:0] req_left_may_one,
   input  logic [31:0] req_left_must_one,
   input  logic [31:0] req_right_may_one,
   input  logic [31:0] req_right_must_one,
   input  logic        req_sel_may_one,
   input  logic        req_sel_must_one,
   input  logic        req_is_signed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_res_may_one,
   output logic [31:0] rsp_res_must_one
);

   localparam int AW = $clog2(WIDTH);
   localparam logic [AW-1:0] SHMASK = AW'(WIDTH - 1);

   typedef struct packed {
      logic [4:0]       func;
      logic [WIDTH-1:0] lz;
      logic [WIDTH-1:0] lo;
      logic [WIDTH-1:0] rz;
      logic [WIDTH-1:0] ro;
      logic             sz;
      logic             so;
      logic             sgn;
   } in_stage_type;

   typedef struct packed {
      logic             cmp;
      kind_type         kind;
      logic [WIDTH-1:0] z;
      logic [WIDTH-1:0] o;
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic [WIDTH-1:0] rz;
      logic [WIDTH-1:0] ro;
      logic [AW-1:0]    sure;
      logic [AW-1:0]    amt;
   } pipe_stage_type;

   typedef struct packed {
      logic [WIDTH-1:0] z;
      logic [WIDTH-1:0] o;
   } mask_pair_type;

   // sum-like combine of the may-built and must-built values
   function automatic mask_pair_type settle(input logic [WIDTH-1:0] vz,
                                            input logic [WIDTH-1:0] vo,
                                            input logic [WIDTH-1:0] nc_in);
      mask_pair_type    r;
      logic [WIDTH-1:0] nc;
      nc  = nc_in | (vz ^ vo);
      r.z = vz | nc;
      r.o = vz & ~nc;
      return r;
   endfunction

   logic           advance;
   in_stage_type   in_in;
   in_stage_type   in_ff;
   logic           in_vld_ff;
   pipe_stage_type pipe0_in;
   pipe_stage_type pipe_in [1:WIDTH];
   pipe_stage_type pipe_ff [0:WIDTH];
   logic [WIDTH:0] vld_ff;

   // whole pipeline moves unless the result register is held
   assign advance   = !(vld_ff[WIDTH] && rsp_stall);
   assign req_stall = !advance;

   // input register
   always_comb begin
      in_in.func = req_func;
      in_in.lz   = WIDTH'(req_left_may_one);
      in_in.lo   = WIDTH'(req_left_must_one);
      in_in.rz   = WIDTH'(req_right_may_one);
      in_in.ro   = WIDTH'(req_right_must_one);
      in_in.sz   = req_sel_may_one;
      in_in.so   = req_sel_must_one;
      in_in.sgn  = req_is_signed;
   end

   // decode, simple operations, compares, add/sub/neg
   always_comb begin
      func_type      f;
      logic          lu;
      logic          ru;
      logic          u;
      logic          differ;
      logic          same;
      logic          ca;
      logic          cb;
      logic          c_true;
      logic          c_false;
      mask_pair_type sp;
      f       = func_type'(in_ff.func);
      lu      = (in_ff.lz == '0) && (in_ff.lo == '1);
      ru      = (in_ff.rz == '0) && (in_ff.ro == '1);
      u       = lu || ru;
      differ  = ((in_ff.ro & ~in_ff.lz) != '0) || ((in_ff.lo & ~in_ff.rz) != '0);
      same    = (in_ff.lz == in_ff.lo) && (in_ff.rz == in_ff.ro) && (in_ff.lz == in_ff.rz);
      ca      = 1'b0;
      cb      = 1'b0;
      c_true  = 1'b0;
      c_false = 1'b0;
      sp      = '0;

      pipe0_in.cmp  = 1'b0;
      pipe0_in.kind = KIND_PASS;
      pipe0_in.z    = '1;
      pipe0_in.o    = '0;
      pipe0_in.a    = in_ff.lz;
      pipe0_in.b    = in_ff.lo;
      pipe0_in.rz   = in_ff.rz;
      pipe0_in.ro   = in_ff.ro;
      pipe0_in.sure = ~(in_ff.ro[AW-1:0] ^ in_ff.rz[AW-1:0]) & SHMASK;
      pipe0_in.amt  = in_ff.rz[AW-1:0];

      if (f == FN_NOT || f == FN_NEG) begin
         u = lu;
      end else if (f == FN_MUX) begin
         u = lu || ru || (!in_ff.sz && in_ff.so);
      end

      if (in_ff.func <= 5'(FN_MEET)) begin
         if (u) begin
            pipe0_in.z = '0;
            pipe0_in.o = '1;
         end else begin
            case (f)
               FN_AND: begin
                  pipe0_in.z = in_ff.lz & in_ff.rz;
                  pipe0_in.o = in_ff.lo & in_ff.ro;
               end
               FN_OR: begin
                  pipe0_in.z = in_ff.lz | in_ff.rz;
                  pipe0_in.o = in_ff.lo | in_ff.ro;
               end
               FN_XOR: begin
                  pipe0_in.z = (in_ff.lz & ~in_ff.ro) | (in_ff.rz & ~in_ff.lo);
                  pipe0_in.o = (in_ff.ro & ~in_ff.lz) | (in_ff.lo & ~in_ff.rz);
               end
               FN_NOT: begin
                  pipe0_in.z = ~in_ff.lo;
                  pipe0_in.o = ~in_ff.lz;
               end
               FN_ADD: begin
                  sp = settle(in_ff.lz + in_ff.rz, in_ff.lo + in_ff.ro,
                              (in_ff.lz ^ in_ff.lo) | (in_ff.rz ^ in_ff.ro));
                  pipe0_in.z = sp.z;
                  pipe0_in.o = sp.o;
               end
               FN_SUB: begin
                  sp = settle(in_ff.lo - in_ff.rz, in_ff.lz - in_ff.ro,
                              (in_ff.lz ^ in_ff.lo) | (in_ff.rz ^ in_ff.ro));
                  pipe0_in.z = sp.z;
                  pipe0_in.o = sp.o;
               end
               FN_NEG: begin
                  sp = settle(-in_ff.lz, -in_ff.lo, in_ff.lz ^ in_ff.lo);
                  pipe0_in.z = sp.z;
                  pipe0_in.o = sp.o;
               end
               FN_MUL: begin
                  pipe0_in.kind = KIND_MUL;
                  pipe0_in.z    = '0;
                  pipe0_in.o    = '0;
               end
               FN_SHL: begin
                  pipe0_in.kind = KIND_SHL;
                  pipe0_in.z    = '0;
                  pipe0_in.o    = '1;
               end
               FN_SHR: begin
                  pipe0_in.kind = KIND_SHR;
                  pipe0_in.z    = '0;
                  pipe0_in.o    = '1;
               end
               FN_SHRS: begin
                  pipe0_in.kind = KIND_SHRS;
                  pipe0_in.z    = '0;
                  pipe0_in.o    = '1;
               end
               FN_MUX: begin
                  if (in_ff.so) begin
                     pipe0_in.z = in_ff.lz;
                     pipe0_in.o = in_ff.lo;
                  end else if (!in_ff.sz) begin
                     pipe0_in.z = in_ff.rz;
                     pipe0_in.o = in_ff.ro;
                  end else begin
                     pipe0_in.z = in_ff.lz | in_ff.rz;
                     pipe0_in.o = in_ff.lo & in_ff.ro;
                  end
               end
               FN_JOIN: begin
                  pipe0_in.z = in_ff.lz | in_ff.rz;
                  pipe0_in.o = in_ff.lo & in_ff.ro;
               end
               default: begin
                  pipe0_in.z = in_ff.lz & in_ff.rz;
                  pipe0_in.o = in_ff.lo | in_ff.ro;
               end
            endcase
         end
      end else if (in_ff.func <= 5'(FN_GE)) begin
         pipe0_in.cmp = 1'b1;
         if (lu || ru) begin
            pipe0_in.z = '0;
            pipe0_in.o = WIDTH'(1);
         end else begin
            case (f)
               FN_EQ: begin
                  c_false = differ;
                  c_true  = !differ && same;
               end
               FN_NE: begin
                  c_true  = differ;
                  c_false = !differ && same;
               end
               default: begin
                  case (f)
                     FN_LT: begin
                        ca = in_ff.lz < in_ff.ro;
                        cb = in_ff.lo < in_ff.rz;
                     end
                     FN_LE: begin
                        ca = in_ff.lz <= in_ff.ro;
                        cb = in_ff.lo <= in_ff.rz;
                     end
                     FN_GT: begin
                        ca = in_ff.lz > in_ff.ro;
                        cb = in_ff.lo > in_ff.rz;
                     end
                     default: begin
                        ca = in_ff.lz >= in_ff.ro;
                        cb = in_ff.lo >= in_ff.rz;
                     end
                  endcase
                  if (in_ff.sgn && (in_ff.lz[WIDTH-1] | in_ff.lo[WIDTH-1] |
                                    in_ff.rz[WIDTH-1] | in_ff.ro[WIDTH-1])) begin
                     c_true  = 1'b0;
                     c_false = 1'b0;
                  end else if (f == FN_LT || f == FN_LE) begin
                     c_true  = ca;
                     c_false = !ca && !cb;
                  end else begin
                     c_false = !ca;
                     c_true  = ca && cb;
                  end
               end
            endcase
            if (c_true) begin
               pipe0_in.z = WIDTH'(1);
               pipe0_in.o = WIDTH'(1);
            end else if (c_false) begin
               pipe0_in.z = '0;
               pipe0_in.o = '0;
            end else begin
               pipe0_in.z = WIDTH'(1);
               pipe0_in.o = '0;
            end
         end
      end
   end

   // iteration stages: multiplier bit k or candidate shift amount k
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      mask_pair_type step_pair;
      logic          hit;

      assign step_pair = settle(pipe_ff[k].a + pipe_ff[k].z, pipe_ff[k].b + pipe_ff[k].o,
                                (pipe_ff[k].a ^ pipe_ff[k].b) | (pipe_ff[k].z ^ pipe_ff[k].o));
      assign hit = ((pipe_ff[k].sure & (AW'(k) ^ pipe_ff[k].amt)) == '0);

      always_comb begin
         pipe_in[k+1] = pipe_ff[k];
         case (pipe_ff[k].kind)
            KIND_MUL: begin
               if (pipe_ff[k].rz[k]) begin
                  if (pipe_ff[k].ro[k]) begin
                     pipe_in[k+1].z = step_pair.z;
                     pipe_in[k+1].o = step_pair.o;
                  end else begin
                     pipe_in[k+1].z = pipe_ff[k].z | step_pair.z;
                     pipe_in[k+1].o = pipe_ff[k].o & step_pair.o;
                  end
               end
               pipe_in[k+1].a = pipe_ff[k].a << 1;
               pipe_in[k+1].b = pipe_ff[k].b << 1;
            end
            KIND_SHL: begin
               if (hit) begin
                  pipe_in[k+1].z = pipe_ff[k].z | (pipe_ff[k].a << k);
                  pipe_in[k+1].o = pipe_ff[k].o & (pipe_ff[k].b << k);
               end
            end
            KIND_SHR: begin
               if (hit) begin
                  pipe_in[k+1].z = pipe_ff[k].z | (pipe_ff[k].a >> k);
                  pipe_in[k+1].o = pipe_ff[k].o & (pipe_ff[k].b >> k);
               end
            end
            KIND_SHRS: begin
               if (hit) begin
                  pipe_in[k+1].z = pipe_ff[k].z | $unsigned($signed(pipe_ff[k].a) >>> k);
                  pipe_in[k+1].o = pipe_ff[k].o & $unsigned($signed(pipe_ff[k].b) >>> k);
               end
            end
            default: begin
               pipe_in[k+1] = pipe_ff[k];
            end
         endcase
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         vld_ff    <= '0;
      end else if (advance) begin
         in_vld_ff <= req_valid;
         vld_ff    <= {vld_ff[WIDTH-1:0], in_vld_ff};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff      <= in_in;
         pipe_ff[0] <= pipe0_in;
         for (int i = 1; i <= WIDTH; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // result transfer
   assign rsp_valid        = vld_ff[WIDTH];
   assign rsp_res_may_one  = 32'(pipe_ff[WIDTH].z);
   assign rsp_res_must_one = 32'(pipe_ff[WIDTH].o);

`ifndef SYNTH
   // a comparison answers in bit 0 only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pipe_ff[WIDTH].cmp |->
         (pipe_ff[WIDTH].z[WIDTH-1:1] == '0) && (pipe_ff[WIDTH].o[WIDTH-1:1] == '0))
      else $error("compare result has upper bits set");

   // a held result freezes every stage's valid bit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff) && $stable(in_vld_ff))
      else $error("pipeline moved while result was held");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_vld_ff)
      else $error("valid bit survived reset");

   // the decode stage holds an item only if the input register held one as it advanced
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_vld_ff |=> !vld_ff[0])
      else $error("decode stage valid without an input item");
`endif

endmodule
